>>> sv/pidaw_pkg.sv
// Shared types, constants and fixed-point helpers for the PID controller.
package pidaw_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
  localparam int EXT_WIDTH     = DATA_WIDTH + 2;
  localparam int CFG_IDX_WIDTH = 3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [EXT_WIDTH-1:0]  ext_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN_DT,
    REG_DERIV_GAIN_RATE,
    REG_SETPOINT,
    REG_OUT_UPPER,
    REG_OUT_LOWER
  } cfg_reg_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_scale;
  } mul_ctl_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  function automatic ext_t ext(data_t v);
    return ext_t'(v);
  endfunction

  function automatic data_t sat_ext(ext_t v);
    data_t r;
    if (v > ext(DATA_MAX)) begin
      r = DATA_MAX;
    end else if (v < ext(DATA_MIN)) begin
      r = DATA_MIN;
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // Limit to upper first, then raise to lower: lower wins if they cross.
  function automatic data_t clamp_ext(ext_t v, data_t upper, data_t lower);
    ext_t r;
    r = v;
    if (r > ext(upper)) begin
      r = ext(upper);
    end
    if (r < ext(lower)) begin
      r = ext(lower);
    end
    return r[DATA_WIDTH-1:0];
  endfunction

  // Drop the fraction bits rounding toward zero, then saturate.
  function automatic data_t scale_prod(prod_t p);
    prod_t bias;
    prod_t q;
    data_t r;
    bias = '0;
    if (p[PROD_WIDTH-1]) begin
      bias[FRAC_BITS-1:0] = '1;
    end
    q = (p + bias) >>> FRAC_BITS;
    if (q > prod_t'(DATA_MAX)) begin
      r = DATA_MAX;
    end else if (q < prod_t'(DATA_MIN)) begin
      r = DATA_MIN;
    end else begin
      r = q[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/pidaw_fxmul.sv
// Two-stage fixed-point multiplier: registered product, then registered scaled result.
module pidaw_fxmul import pidaw_pkg::*; (
  input  logic     clk,
  input  mul_ctl_t ctl,
  input  data_t    a,
  input  data_t    b,
  output data_t    y
);

  prod_t prod_r;
  prod_t prod_nxt;
  data_t y_r;

  assign prod_nxt = prod_t'(a) * prod_t'(b);

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod_r <= prod_nxt;
    end
    if (ctl.ld_scale) begin
      y_r <= scale_prod(prod_r);
    end
  end

  assign y = y_r;

endmodule

>>> sv/pid_controller_antiwindup.sv
// Top level of the PID controller with integral clamping.
//
// Input channel: in_valid / in_stall / in_measurement, one measured sample
// per item, signed Q16.16. Result channel: out_valid / out_stall /
// out_drive, one clamped drive value per item, in input order.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_idx
// (0 Kp, 1 Ki*dt, 2 Kd/dt, 3 setpoint, 4 upper clamp, 5 lower clamp);
// other indices are ignored. Write only while the block is idle.
// Each accepted item passes through registered steps in this order:
// error, product, scaling, integral update, output sum and clamp.
// Throughput: one item per cycle while the receiver does not stall;
// each stage is a pipeline register with its own valid bit, so
// bubbles close up under backpressure. When the receiver stalls, the
// output register holds its item and the stages behind it keep
// filling; in_stall rises only once every stage holds an item.
// Reset clears all stage valids, the previous error and the integral
// accumulator, and loads the configuration reset values (gains and
// setpoint zero, clamps at the full signed range).
module pid_controller_antiwindup import pidaw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  data_t                    in_measurement,
  output logic                     out_valid,
  input  logic                     out_stall,
  output data_t                    out_drive,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx,
  input  logic [DATA_WIDTH-1:0]    cfg_wdata
);

  data_t prop_gain_r, integ_gain_dt_r, deriv_gain_rate_r, setpoint_r;
  data_t out_upper_r, out_lower_r;

  logic  v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic  rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

  data_t meas_r;
  data_t err_r, diff_r;
  data_t last_err_r, acc_r;
  data_t p5_r, d5_r;
  data_t out_drive_r;

  data_t err_nxt, diff_nxt, acc_nxt, sum_sat, drive_nxt;
  data_t p4, i4, d4;

  mul_ctl_t mul_ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r       <= '0;
      integ_gain_dt_r   <= '0;
      deriv_gain_rate_r <= '0;
      setpoint_r        <= '0;
      out_upper_r       <= DATA_MAX;
      out_lower_r       <= DATA_MIN;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_PROP_GAIN:       prop_gain_r       <= cfg_wdata;
        REG_INTEG_GAIN_DT:   integ_gain_dt_r   <= cfg_wdata;
        REG_DERIV_GAIN_RATE: deriv_gain_rate_r <= cfg_wdata;
        REG_SETPOINT:        setpoint_r        <= cfg_wdata;
        REG_OUT_UPPER:       out_upper_r       <= cfg_wdata;
        REG_OUT_LOWER:       out_lower_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy_out = !out_valid_r || !out_stall;
    rdy5    = !v5_r || rdy_out;
    rdy4    = !v4_r || rdy5;
    rdy3    = !v3_r || rdy4;
    rdy2    = !v2_r || rdy3;
    rdy1    = !v1_r || rdy2;
  end

  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy4)    v4_r        <= v3_r;
      if (rdy5)    v5_r        <= v4_r;
      if (rdy_out) out_valid_r <= v5_r;
    end
  end

  always_comb begin
    err_nxt  = sat_ext(ext(setpoint_r) - ext(meas_r));
    diff_nxt = sat_ext(ext(err_nxt) - ext(last_err_r));
    if (integ_gain_dt_r > 0) begin
      acc_nxt = clamp_ext(ext(acc_r) + ext(i4), out_upper_r, out_lower_r);
    end else begin
      acc_nxt = '0;
    end
    sum_sat   = sat_ext(ext(p5_r) + ext(acc_r) + ext(d5_r));
    drive_nxt = clamp_ext(ext(sum_sat), out_upper_r, out_lower_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      acc_r      <= '0;
    end else begin
      if (rdy2 && v1_r) last_err_r <= err_nxt;
      if (rdy5 && v4_r) acc_r      <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      meas_r <= in_measurement;
    end
    if (rdy2 && v1_r) begin
      err_r  <= err_nxt;
      diff_r <= diff_nxt;
    end
    if (rdy5 && v4_r) begin
      p5_r <= p4;
      d5_r <= d4;
    end
    if (rdy_out && v5_r) begin
      out_drive_r <= drive_nxt;
    end
  end

  always_comb begin
    mul_ctl.ld_prod  = rdy3 && v2_r;
    mul_ctl.ld_scale = rdy4 && v3_r;
  end

  pidaw_fxmul u_mul_p (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (prop_gain_r),
    .b   (err_r),
    .y   (p4)
  );

  pidaw_fxmul u_mul_i (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (err_r),
    .b   (integ_gain_dt_r),
    .y   (i4)
  );

  pidaw_fxmul u_mul_d (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (deriv_gain_rate_r),
    .b   (diff_r),
    .y   (d4)
  );

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

endmodule

>>> sv/pidaw_chk.sv
// Port-level checker for the PID controller, bound to the top level.
module pidaw_chk import pidaw_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_stall,
  input data_t in_measurement,
  input logic  out_valid,
  input logic  out_stall,
  input data_t out_drive
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_drive))
    else $error("stalled result item changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_measurement))
    else $error("stalled input item changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind pid_controller_antiwindup pidaw_chk u_pidaw_chk (.*);

>>> tb/sv/pid_controller_antiwindup_tb.sv
// Testbench for the PID controller: random and directed samples, checked against a predictor.
module pid_controller_antiwindup_tb;
  import pidaw_pkg::*;

  localparam int IDLE_PCT = 11;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_B = 3'd7;
  localparam data_t ONE = data_t'(32'sh0001_0000);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  data_t in_measurement = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  data_t out_drive;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx = '0;
  logic [DATA_WIDTH-1:0] cfg_wdata = '0;

  logic calm = 1'b0;
  logic in_taken = 1'b0;
  data_t samples_q[$];
  data_t drive_q[$];
  int issued = 0;
  int results_seen = 0;
  int fails = 0;
  int cycle_count = 0;

  data_t kp, ki_dt, kd_rate, target, upper, lower;
  data_t prev_err, integ;

  pid_controller_antiwindup DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_measurement(in_measurement),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_drive(out_drive),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic data_t saturate(longint v);
    if (v > longint'(DATA_MAX)) begin
      return DATA_MAX;
    end
    if (v < longint'(DATA_MIN)) begin
      return DATA_MIN;
    end
    return data_t'(v);
  endfunction

  function automatic data_t scaled_product(data_t a, data_t b);
    longint p, q;
    p = longint'(a) * longint'(b);
    if (p < 0) begin
      q = -((-p) >>> FRAC_BITS);
    end else begin
      q = p >>> FRAC_BITS;
    end
    return saturate(q);
  endfunction

  function automatic data_t clamp_limits(longint v);
    if (v > longint'(upper)) begin
      v = longint'(upper);
    end
    if (v < longint'(lower)) begin
      v = longint'(lower);
    end
    return data_t'(v);
  endfunction

  function automatic data_t advance_controller(data_t meas);
    data_t err, diff, p_term, d_term;
    err = saturate(longint'(target) - longint'(meas));
    diff = saturate(longint'(err) - longint'(prev_err));
    prev_err = err;
    if (ki_dt > 0) begin
      integ = clamp_limits(longint'(integ) + longint'(scaled_product(err, ki_dt)));
    end else begin
      integ = '0;
    end
    p_term = scaled_product(kp, err);
    d_term = scaled_product(kd_rate, diff);
    return clamp_limits(longint'(saturate(longint'(p_term) + longint'(integ)
                                          + longint'(d_term))));
  endfunction

  function automatic data_t pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r <= 6) begin
      return data_t'(int'($urandom_range(0, 4 << FRAC_BITS)) - (2 << FRAC_BITS));
    end else if (r <= 8) begin
      return data_t'($urandom);
    end
    return ($urandom_range(0, 1) == 1) ? DATA_MAX : DATA_MIN;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (samples_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_measurement <= samples_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pid_controller_antiwindup_tb: FAIL");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  always @(posedge clk) begin : monitor
    data_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      kp = '0;
      ki_dt = '0;
      kd_rate = '0;
      target = '0;
      upper = DATA_MAX;
      lower = DATA_MIN;
      prev_err = '0;
      integ = '0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_we) begin
        case (cfg_idx)
          REG_PROP_GAIN: kp = data_t'(cfg_wdata);
          REG_INTEG_GAIN_DT: ki_dt = data_t'(cfg_wdata);
          REG_DERIV_GAIN_RATE: kd_rate = data_t'(cfg_wdata);
          REG_SETPOINT: target = data_t'(cfg_wdata);
          REG_OUT_UPPER: upper = data_t'(cfg_wdata);
          REG_OUT_LOWER: lower = data_t'(cfg_wdata);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        drive_q.push_back(advance_controller(in_measurement));
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected drive %0d, nothing expected", $time, out_drive);
          fails++;
        end else begin
          want = drive_q.pop_front();
          if (out_drive !== want) begin
            $display("%0t: drive mismatch, expected %0d, got %0d", $time, want, out_drive);
            fails++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, data_t val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(data_t p, data_t i, data_t d, data_t sp, data_t hi, data_t lo);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN_DT, i);
    write_reg(REG_DERIV_GAIN_RATE, d);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_OUT_UPPER, hi);
    write_reg(REG_OUT_LOWER, lo);
  endtask

  task automatic send(data_t m);
    samples_q.push_back(m);
    issued++;
  endtask

  task automatic settle();
    while (results_seen != issued) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    data_t sp, hi, lo, tmp;
    longint walk;
    int mode, n, r;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send('0);
    send(DATA_MAX);
    send(DATA_MIN);
    send(data_t'(1));
    send(data_t'(-1));
    settle();

    write_all(ONE, ONE >>> 1, ONE >>> 2, ONE + (ONE >>> 1), 100 * ONE, -100 * ONE);
    send('0);
    send(ONE);
    send(DATA_MIN);
    send(DATA_MAX);
    send(DATA_MIN);
    send(3 * ONE);
    settle();

    write_all(DATA_MAX, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX, DATA_MIN);
    send(DATA_MAX);
    send(DATA_MIN);
    send('0);
    send(data_t'(-1));
    settle();

    write_all(-ONE, DATA_MIN, ONE, '0, -5 * ONE, 5 * ONE);
    send(10 * ONE);
    send(-10 * ONE);
    send('0);
    settle();

    write_reg(REG_INTEG_GAIN_DT, ONE);
    write_reg(CFG_SPARE_A, DATA_MAX);
    write_reg(CFG_SPARE_B, DATA_MIN);
    send(20 * ONE);
    send(-20 * ONE);
    send(ONE);
    settle();

    for (int ph = 0; ph < 13; ph++) begin
      write_reg(REG_PROP_GAIN, pick_gain());
      write_reg(REG_INTEG_GAIN_DT, pick_gain());
      write_reg(REG_DERIV_GAIN_RATE, pick_gain());
      if ($urandom_range(0, 3) == 0) begin
        sp = data_t'($urandom);
      end else begin
        sp = data_t'(int'($urandom_range(0, 100 << FRAC_BITS)) - (50 << FRAC_BITS));
      end
      write_reg(REG_SETPOINT, sp);
      r = $urandom_range(0, 5);
      if (r == 0) begin
        hi = DATA_MAX;
        lo = DATA_MIN;
      end else if (r == 1) begin
        hi = data_t'(int'($urandom_range(0, 20 << FRAC_BITS)) - (10 << FRAC_BITS));
        lo = hi + data_t'($urandom_range(1, 10 << FRAC_BITS));
      end else begin
        hi = data_t'($urandom_range(0, 200 << FRAC_BITS));
        lo = data_t'(-int'($urandom_range(0, 200 << FRAC_BITS)));
        if (r == 5) begin
          hi = data_t'($urandom);
          lo = data_t'($urandom);
          if (lo > hi) begin
            tmp = hi;
            hi = lo;
            lo = tmp;
          end
        end
      end
      write_reg(REG_OUT_UPPER, hi);
      write_reg(REG_OUT_LOWER, lo);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B, data_t'($urandom));
      end

      calm <= (ph == 5);
      n = (ph == 5) ? 80 : 29;
      mode = $urandom_range(0, 2);
      walk = longint'(sp);
      for (int i = 0; i < n; i++) begin
        walk = longint'(saturate(walk + longint'($urandom_range(0, 2 << FRAC_BITS))
                                 - (longint'(1) << FRAC_BITS)));
        if (mode == 0) begin
          send(data_t'($urandom));
        end else if (mode == 1 || $urandom_range(0, 3) != 0) begin
          send(data_t'(walk));
        end else begin
          send(($urandom_range(0, 1) == 1) ? DATA_MAX : DATA_MIN);
        end
      end
      settle();
    end
    calm <= 1'b0;

    if (fails == 0) begin
      $display("pid_controller_antiwindup_tb: PASS");
    end else begin
      $display("pid_controller_antiwindup_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/pidaw_pkg.sv
sv/pidaw_fxmul.sv
sv/pid_controller_antiwindup.sv
sv/pidaw_chk.sv
tb/sv/pid_controller_antiwindup_tb.sv
